### design/assert_macros.svh
// Assertion macros shared by the RTL of the face-to-triangle block.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge once reset is released.
`define ASSERT_CHECK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Expression must never be true once reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### design/cftt_pkg.sv
// Shared types, widths and codes of the cell-face-to-triangles block.
// No dependencies.
`timescale 1ns / 1ps
package cftt_pkg;

  localparam int MAX_LINES_DEF  = 1024;
  localparam int COORD_BITS_DEF = 32;

  localparam int CNT_W     = 11;  // line count registers
  localparam int IDX_W     = 10;  // line_index field
  localparam int WORD_W    = 32;  // coordinate words on the ports
  localparam int FACE_W    = 31;  // face_index field
  localparam int MAG_W     = 31;  // magnitude of a face index
  localparam int PLANE_W   = 2 * CNT_W;
  localparam int DIV_STEPS = 4;   // quotient bits per divider stage

  localparam logic [1:0] REG_COUNT_X = 2'd0;
  localparam logic [1:0] REG_COUNT_Y = 2'd1;
  localparam logic [1:0] REG_COUNT_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_FACE = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec3_t;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    logic              valid;
    logic              req;
    logic [1:0]        axis;
    logic [IDX_W-1:0]  line_index;
    word_t             line_value;
    logic              rev;
    logic              bad;
    logic [MAG_W-1:0]  iz;
  } side_t;

  // Control of the lookup stage.
  typedef struct packed {
    logic       valid;
    logic       req;
    logic [1:0] axis;
    logic       rev;
    logic       err;
  } look_t;

endpackage

### design/cell_face_to_triangles_core.sv
// Top level of the cell-face-to-triangles block.
// Uses cftt_pkg, cftt_div, cftt_lines and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A load word writes one grid-line coordinate and gives no result; a face word
// gives two triangle words, or one flagged word when its decoded cell index is
// out of range, its axis is none or the x or y line count is zero. Faces are
// decoded by two pipelined dividers (cell index by nx*ny, then the rest by nx),
// 4 quotient bits per stage, followed by a range check with table read and a
// quad assembly stage. The word passes 17 registers (entry, 8 + 6 divider
// stages, lookup, output). One word enters per cycle while the pipeline is not
// held; a face keeps the single output register until both its triangle words
// are taken, and a load passes it by. The whole pipeline holds while a result
// is stalled. Line counts may only be written while the block is empty.
module cell_face_to_triangles_core #(
  parameter int MAX_LINES  = cftt_pkg::MAX_LINES_DEF,
  parameter int COORD_BITS = cftt_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [cftt_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [1:0]                    axis_i,
  input  logic [cftt_pkg::IDX_W-1:0]    line_index_i,
  input  logic signed [31:0]            line_value_i,
  input  logic signed [cftt_pkg::FACE_W-1:0] face_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            vertex1_x_o,
  output logic signed [31:0]            vertex1_y_o,
  output logic signed [31:0]            vertex1_z_o,
  output logic signed [31:0]            vertex2_x_o,
  output logic signed [31:0]            vertex2_y_o,
  output logic signed [31:0]            vertex2_z_o,
  output logic signed [31:0]            vertex3_x_o,
  output logic signed [31:0]            vertex3_y_o,
  output logic signed [31:0]            vertex3_z_o,
  output logic [2:0]                    normal_code_o,
  output logic                          range_error_o,
  output logic                          last_o
);

  localparam int AddrW   = $clog2(MAX_LINES);
  localparam int DivLat1 = (cftt_pkg::MAG_W + cftt_pkg::DIV_STEPS - 1) / cftt_pkg::DIV_STEPS;
  localparam int DivLat2 = (cftt_pkg::PLANE_W + cftt_pkg::DIV_STEPS - 1) / cftt_pkg::DIV_STEPS;
  localparam int SbLen   = DivLat1 + DivLat2;

  // ---------------- configuration ----------------
  logic [cftt_pkg::CNT_W-1:0]   cnt_x_q, cnt_y_q, cnt_z_q;
  logic [cftt_pkg::PLANE_W-1:0] plane_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_x_q <= cftt_pkg::CNT_W'(2);
      cnt_y_q <= cftt_pkg::CNT_W'(2);
      cnt_z_q <= cftt_pkg::CNT_W'(2);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cftt_pkg::REG_COUNT_X: cnt_x_q <= cfg_data_i;
        cftt_pkg::REG_COUNT_Y: cnt_y_q <= cfg_data_i;
        cftt_pkg::REG_COUNT_Z: cnt_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= cftt_pkg::PLANE_W'(cnt_x_q) * cftt_pkg::PLANE_W'(cnt_y_q);
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_valid_q, phase_q, err_q;

  // Advance when the output register is empty or gives away its last word.
  assign adv        = !out_valid_q || (!out_stall_i && (err_q || phase_q));
  assign in_stall_o = !adv;

  // ---------------- entry stage ----------------
  cftt_pkg::side_t          a_d, a_q;
  logic [cftt_pkg::MAG_W-1:0] mag_q;
  logic [31:0]              raw32, mag32;

  always_comb begin
    raw32 = {1'b0, face_index_i};
    mag32 = face_index_i[cftt_pkg::FACE_W-1] ? (32'h8000_0000 - raw32) : raw32;
    a_d            = '0;
    a_d.valid      = in_valid_i;
    a_d.req        = req_type_i;
    a_d.axis       = axis_i;
    a_d.line_index = line_index_i;
    a_d.line_value = line_value_i;
    a_d.rev        = !face_index_i[cftt_pkg::FACE_W-1];
    a_d.bad        = (axis_i == cftt_pkg::AXIS_NONE) || (cnt_x_q == '0) || (cnt_y_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (adv) begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q <= mag32[cftt_pkg::MAG_W-1:0];
    end
  end

  // ---------------- dividers ----------------
  logic [cftt_pkg::MAG_W-1:0]   quot1;
  logic [cftt_pkg::PLANE_W-1:0] rem1;
  logic [cftt_pkg::PLANE_W-1:0] quot2;
  logic [cftt_pkg::CNT_W-1:0]   rem2;

  cftt_div #(
    .NUM_W (cftt_pkg::MAG_W),
    .DEN_W (cftt_pkg::PLANE_W)
  ) u_div_plane (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (mag_q),
    .den_i  (plane_q),
    .quot_o (quot1),
    .rem_o  (rem1)
  );

  cftt_div #(
    .NUM_W (cftt_pkg::PLANE_W),
    .DEN_W (cftt_pkg::CNT_W)
  ) u_div_row (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (rem1),
    .den_i  (cnt_x_q),
    .quot_o (quot2),
    .rem_o  (rem2)
  );

  cftt_pkg::side_t sb_q [SbLen];
  cftt_pkg::side_t sb_d [SbLen];

  always_comb begin
    for (int i = 0; i < SbLen; i++) begin
      sb_d[i] = (i == 0) ? a_q : sb_q[(i == 0) ? 0 : i - 1];
      if (i == DivLat1) begin
        sb_d[i].iz = quot1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SbLen; i++) begin
        sb_q[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < SbLen; i++) begin
        sb_q[i] <= sb_d[i];
      end
    end
  end

  // ---------------- range check and table access ----------------
  cftt_pkg::side_t tail;
  cftt_pkg::look_t look_d, look_q;
  logic [31:0] ix32, iy32, iz32, lx32, ly32, lz32, pos32, max32;
  logic        in_range;
  logic [AddrW-1:0] ax_a, ax_b, ay_a, ay_b, az_a, az_b, waddr;
  logic [COORD_BITS-1:0] wdata;
  logic [63:0] wide_in;
  logic        we_ok;

  assign tail = sb_q[SbLen-1];

  always_comb begin
    max32 = 32'(MAX_LINES);
    ix32  = 32'(rem2);
    iy32  = 32'(quot2);
    iz32  = 32'(tail.iz);
    lx32  = (32'(cnt_x_q) > max32) ? max32 : 32'(cnt_x_q);
    ly32  = (32'(cnt_y_q) > max32) ? max32 : 32'(cnt_y_q);
    lz32  = (32'(cnt_z_q) > max32) ? max32 : 32'(cnt_z_q);
    case (tail.axis)
      cftt_pkg::AXIS_X: in_range = (ix32 < lx32) && (iy32 + 32'd1 < ly32)
                                   && (iz32 + 32'd1 < lz32);
      cftt_pkg::AXIS_Y: in_range = (ix32 + 32'd1 < lx32) && (iy32 < ly32)
                                   && (iz32 + 32'd1 < lz32);
      default:          in_range = (ix32 + 32'd1 < lx32) && (iy32 + 32'd1 < ly32)
                                   && (iz32 < lz32);
    endcase
    look_d       = '0;
    look_d.valid = tail.valid;
    look_d.req   = tail.req;
    look_d.axis  = tail.axis;
    look_d.rev   = tail.rev;
    look_d.err   = tail.bad || !in_range;

    ax_a = ix32[AddrW-1:0];
    ax_b = ix32[AddrW-1:0] + AddrW'(1);
    ay_a = iy32[AddrW-1:0];
    ay_b = iy32[AddrW-1:0] + AddrW'(1);
    az_a = iz32[AddrW-1:0];
    az_b = iz32[AddrW-1:0] + AddrW'(1);

    pos32   = 32'(tail.line_index);
    waddr   = pos32[AddrW-1:0];
    wide_in = {32'b0, tail.line_value};
    wdata   = wide_in[COORD_BITS-1:0];
    we_ok   = tail.valid && (tail.req == cftt_pkg::REQ_LOAD) && (pos32 < max32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q <= '0;
    end else if (adv) begin
      look_q <= look_d;
    end
  end

  logic [COORD_BITS-1:0] x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;

  cftt_lines #(.DEPTH(MAX_LINES), .WIDTH(COORD_BITS)) u_lines_x (
    .clk_i     (clk_i),
    .en_i      (adv),
    .we_i      (we_ok && (tail.axis == cftt_pkg::AXIS_X)),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ax_a),
    .raddr_b_i (ax_b),
    .rdata_a_o (x0_r),
    .rdata_b_o (x1_r)
  );

  cftt_lines #(.DEPTH(MAX_LINES), .WIDTH(COORD_BITS)) u_lines_y (
    .clk_i     (clk_i),
    .en_i      (adv),
    .we_i      (we_ok && (tail.axis == cftt_pkg::AXIS_Y)),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ay_a),
    .raddr_b_i (ay_b),
    .rdata_a_o (y0_r),
    .rdata_b_o (y1_r)
  );

  cftt_lines #(.DEPTH(MAX_LINES), .WIDTH(COORD_BITS)) u_lines_z (
    .clk_i     (clk_i),
    .en_i      (adv),
    .we_i      (we_ok && (tail.axis == cftt_pkg::AXIS_Z)),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (az_a),
    .raddr_b_i (az_b),
    .rdata_a_o (z0_r),
    .rdata_b_o (z1_r)
  );

  // ---------------- quad assembly and output register ----------------
  logic [63:0] x0w, x1w, y0w, y1w, z0w, z1w;
  cftt_pkg::word_t x0, x1, y0, y1, z0, z1, ca, cb;
  cftt_pkg::vec3_t quad_d [4];
  cftt_pkg::vec3_t quad_q [4];
  logic [1:0] axis_q;
  logic       rev_q;

  always_comb begin
    x0w = 64'(x0_r);
    x1w = 64'(x1_r);
    y0w = 64'(y0_r);
    y1w = 64'(y1_r);
    z0w = 64'(z0_r);
    z1w = 64'(z1_r);
    x0 = x0w[31:0];
    x1 = x1w[31:0];
    y0 = y0w[31:0];
    y1 = y1w[31:0];
    z0 = z0w[31:0];
    z1 = z1w[31:0];
    ca = '0;
    cb = '0;
    case (look_q.axis)
      cftt_pkg::AXIS_X: begin
        ca = look_q.rev ? z1 : z0;
        cb = look_q.rev ? z0 : z1;
        quad_d[0] = '{x: x0, y: y0, z: ca};
        quad_d[1] = '{x: x0, y: y1, z: ca};
        quad_d[2] = '{x: x0, y: y1, z: cb};
        quad_d[3] = '{x: x0, y: y0, z: cb};
      end
      cftt_pkg::AXIS_Y: begin
        ca = look_q.rev ? z0 : z1;
        cb = look_q.rev ? z1 : z0;
        quad_d[0] = '{x: x0, y: y0, z: ca};
        quad_d[1] = '{x: x1, y: y0, z: ca};
        quad_d[2] = '{x: x1, y: y0, z: cb};
        quad_d[3] = '{x: x0, y: y0, z: cb};
      end
      default: begin
        ca = look_q.rev ? y1 : y0;
        cb = look_q.rev ? y0 : y1;
        quad_d[0] = '{x: x0, y: ca, z: z0};
        quad_d[1] = '{x: x1, y: ca, z: z0};
        quad_d[2] = '{x: x1, y: cb, z: z0};
        quad_d[3] = '{x: x0, y: cb, z: z0};
      end
    endcase
    // Flagged faces carry all-zero corners.
    if (look_q.err) begin
      for (int k = 0; k < 4; k++) begin
        quad_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      err_q       <= 1'b0;
    end else if (adv) begin
      out_valid_q <= look_q.valid && (look_q.req == cftt_pkg::REQ_FACE);
      phase_q     <= 1'b0;
      err_q       <= look_q.err;
    end else if (out_valid_q && !out_stall_i) begin
      // First triangle taken: move on to the second.
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        quad_q[k] <= quad_d[k];
      end
      axis_q <= look_q.axis;
      rev_q  <= look_q.rev;
    end
  end

  cftt_pkg::vec3_t v2, v3;

  assign v2 = phase_q ? quad_q[2] : quad_q[1];
  assign v3 = phase_q ? quad_q[3] : quad_q[2];

  assign out_valid_o   = out_valid_q;
  assign vertex1_x_o   = quad_q[0].x;
  assign vertex1_y_o   = quad_q[0].y;
  assign vertex1_z_o   = quad_q[0].z;
  assign vertex2_x_o   = v2.x;
  assign vertex2_y_o   = v2.y;
  assign vertex2_z_o   = v2.z;
  assign vertex3_x_o   = v3.x;
  assign vertex3_y_o   = v3.y;
  assign vertex3_z_o   = v3.z;
  assign normal_code_o = err_q ? 3'd0 : {axis_q, rev_q};
  assign range_error_o = err_q;
  assign last_o        = err_q || phase_q;

  // ---------------- assertions ----------------
  `ASSERT_CHECK(a_err_is_last, clk_i, rst_ni, (out_valid_o && range_error_o) |-> last_o)
  `ASSERT_CHECK(a_err_code_zero, clk_i, rst_ni,
                (out_valid_o && range_error_o) |-> (normal_code_o == 3'd0))
  `ASSERT_CHECK(a_phase_after_take, clk_i, rst_ni,
                $rose(phase_q) |-> $past(out_valid_q && !out_stall_i && !err_q))
  `ASSERT_NEVER(a_stall_when_empty, clk_i, rst_ni, !out_valid_q && in_stall_o)

endmodule

### design/cftt_div.sv
// Pipelined restoring divider with a quasi-static divisor, DIV_STEPS bits a stage.
// Uses cftt_pkg for the step count.
`timescale 1ns / 1ps
module cftt_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 22
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int Steps  = cftt_pkg::DIV_STEPS;
  localparam int Stages = (NUM_W + Steps - 1) / Steps;
  localparam int PadW   = Stages * Steps;

  logic [PadW-1:0]  num_q [Stages];
  logic [DEN_W-1:0] rem_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [PadW-1:0]  num_in;
    logic [DEN_W-1:0] rem_in;
    logic [PadW-1:0]  num_d;
    logic [DEN_W-1:0] rem_d;

    if (s == 0) begin : g_first
      assign num_in = PadW'(num_i);
      assign rem_in = '0;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
    end

    // Shift the next dividend bit into the remainder; quotient bits fill in below.
    always_comb begin
      logic [DEN_W:0] t;
      num_d = num_in;
      rem_d = rem_in;
      for (int k = 0; k < Steps; k++) begin
        t = {rem_d, num_d[PadW-1]};
        num_d = num_d << 1;
        if (t >= {1'b0, den_i}) begin
          t = t - {1'b0, den_i};
          num_d[0] = 1'b1;
        end
        rem_d = t[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_d;
        rem_q[s] <= rem_d;
      end
    end
  end

  assign quot_o = num_q[Stages-1][NUM_W-1:0];
  assign rem_o  = rem_q[Stages-1];

endmodule

### design/cftt_lines.sv
// One grid-line coordinate table: one write port, two registered read ports.
// Standalone; no package use.
`timescale 1ns / 1ps
module cftt_lines #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Hold read data while the pipeline is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[waddr_i] <= wdata_i;
      end
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule
